[rtl/core/protected_id_table_access_filter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the protected id table access filter
// Shared clocking and reset gating for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PROTECTED_ID_TABLE_ACCESS_FILTER_MACROS_SVH
`define PROTECTED_ID_TABLE_ACCESS_FILTER_MACROS_SVH

// Plain property on clk, disabled while in reset.
`define PITAF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define PITAF_ASSERT_IMPL(label, ante, cons, msg) \
  `PITAF_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define PITAF_ASSERT_NEXT(label, ante, cons, msg) \
  `PITAF_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/core/pitaf_pkg.sv]
// ----------------------------------------------------------------------------
// pitaf_pkg
// Types and constants of the protected id table access filter.
// ----------------------------------------------------------------------------
package pitaf_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Process access rights
  localparam logic [31:0] ACC_TERMINATE     = 32'h0000_0001;
  localparam logic [31:0] ACC_CREATE_THREAD = 32'h0000_0002;
  localparam logic [31:0] ACC_VM_OPERATION  = 32'h0000_0008;
  localparam logic [31:0] ACC_VM_READ       = 32'h0000_0010;
  localparam logic [31:0] ACC_DUP_HANDLE    = 32'h0000_0040;

  localparam logic [31:0] STRIP_DEFAULT = ACC_TERMINATE | ACC_CREATE_THREAD |
                                          ACC_VM_OPERATION | ACC_VM_READ |
                                          ACC_DUP_HANDLE;

  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,   // done or matched
    ST_MISS = 2'd1,   // not found or passed
    ST_FULL = 2'd2,
    ST_ZERO = 2'd3    // zero id rejected
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

[rtl/core/protected_id_table_access_filter.sv]
// ----------------------------------------------------------------------------
// protected_id_table_access_filter
// Table of protected process ids that filters the access mask of handle opens.
//
// One request at a time. The id table sits in a single-port-read RAM with a
// registered read; a scan walks it one slot per cycle. An open check or remove
// scans up to the high-water slot, an add up to the first free slot, while
// clear, kernel, empty-table open, zero-id and full-table requests skip the
// scan; the worst case is set by the slot scan through the RAM read port.
// Occupancy is tracked by one valid flop per slot, so reset and clear take
// effect at once with no sweep. A new request is taken while a finished
// result still waits in the output register. strip_mask may only be written
// while no request is in flight.
// ----------------------------------------------------------------------------
`include "protected_id_table_access_filter_macros.svh"

module protected_id_table_access_filter import pitaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_process_id,
  input  logic        in_kernel_handle,
  input  logic [31:0] in_access_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_access_out,
  output logic [6:0]  out_entry_count
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [31:0]           strip_r;
  logic [SLOT_COUNT-1:0] valid_r;      // slot occupied
  logic [CNT_W-1:0]      cnt_r;        // occupied slots
  logic [IDX_W-1:0]      top_r;        // high-water slot

  // latched request
  kind_t                 kind_r;
  logic [31:0]           id_r;
  logic [31:0]           acc_r;

  // scan pipeline
  logic [IDX_W-1:0]      rd_idx_r;     // address presented to the RAM
  logic [IDX_W-1:0]      cmp_idx_r;    // slot whose data is in rdata_r
  logic                  cmp_vld_r;
  logic [31:0]           rdata_r;
  logic [IDX_W-1:0]      below_r;      // highest occupied slot seen below

  // result of the request in flight
  status_t               res_status_r;
  logic [31:0]           res_access_r;

  // output register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [31:0]           out_access_r;
  logic [6:0]            out_count_r;

  logic [31:0]           id_mem [SLOT_COUNT];

  // --------------------------------------------------------------------------
  // Decode
  // --------------------------------------------------------------------------
  logic  in_xfer;
  logic  out_free;
  kind_t in_kind_e;
  logic  slot_valid;
  logic  slot_match;
  logic  at_top;
  logic  mem_we;

  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign in_kind_e  = kind_t'(in_kind);
  assign in_stall   = (state_r != S_IDLE);

  assign slot_valid = valid_r[cmp_idx_r];
  assign slot_match = slot_valid && (rdata_r == id_r);
  assign at_top     = (cmp_idx_r == top_r);

  // add writes the first free slot the scan reaches
  assign mem_we = (state_r == S_SCAN) && cmp_vld_r && (kind_r == KIND_ADD) && !slot_valid;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_kind_e)
            KIND_OPEN: begin
              if (in_kernel_handle || (cnt_r == '0) || (in_process_id == 32'd0)) begin
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_ADD: begin
              if ((in_process_id == 32'd0) || (cnt_r == CNT_W'(SLOT_COUNT))) begin
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_REMOVE: begin
              state_nxt = (in_process_id == 32'd0) ? S_FINISH : S_SCAN;
            end
            KIND_CLEAR: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cmp_vld_r) begin
          unique case (kind_r)
            KIND_ADD: begin
              if (!slot_valid) state_nxt = S_FINISH;
            end
            default: begin
              if (slot_match || at_top) state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers and table bookkeeping
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      strip_r     <= STRIP_DEFAULT;
      valid_r     <= '0;
      cnt_r       <= '0;
      top_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) strip_r <= cfg_wdata;

      if ((state_r == S_IDLE) && in_xfer && (in_kind_e == KIND_CLEAR)) begin
        valid_r <= '0;
        cnt_r   <= '0;
        top_r   <= '0;
      end

      // scan pipeline: one slot issued and one compared per cycle
      cmp_vld_r <= (state_r == S_SCAN) && (state_nxt == S_SCAN);

      if ((state_r == S_SCAN) && cmp_vld_r) begin
        unique case (kind_r)
          KIND_ADD: begin
            if (!slot_valid) begin
              valid_r[cmp_idx_r] <= 1'b1;
              cnt_r              <= cnt_r + CNT_W'(1);
              if (cmp_idx_r > top_r) top_r <= cmp_idx_r;
            end
          end
          KIND_REMOVE: begin
            if (slot_match) begin
              valid_r[cmp_idx_r] <= 1'b0;
              if (at_top) top_r <= below_r;
              if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end

      // output register takes the result once it is free
      if ((state_r == S_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_xfer) begin
      kind_r   <= in_kind_e;
      id_r     <= in_process_id;
      acc_r    <= in_access_in;
      rd_idx_r <= '0;
      below_r  <= '0;
      // early outcomes; a scan overwrites these
      unique case (in_kind_e)
        KIND_OPEN: begin
          res_status_r <= ST_MISS;
          res_access_r <= in_access_in;
        end
        KIND_ADD: begin
          res_status_r <= (in_process_id == 32'd0) ? ST_ZERO : ST_FULL;
          res_access_r <= 32'd0;
        end
        KIND_REMOVE: begin
          res_status_r <= ST_ZERO;
          res_access_r <= 32'd0;
        end
        KIND_CLEAR: begin
          res_status_r <= ST_DONE;
          res_access_r <= 32'd0;
        end
      endcase
    end

    if (state_r == S_SCAN) begin
      rd_idx_r  <= rd_idx_r + IDX_W'(1);
      cmp_idx_r <= rd_idx_r;
      if (cmp_vld_r) begin
        unique case (kind_r)
          KIND_OPEN: begin
            if (slot_match) begin
              res_status_r <= ST_DONE;
              res_access_r <= acc_r & ~strip_r;
            end else begin
              res_status_r <= ST_MISS;
            end
          end
          KIND_REMOVE: begin
            res_status_r <= slot_match ? ST_DONE : ST_MISS;
            if (slot_valid) below_r <= cmp_idx_r;
          end
          default: res_status_r <= ST_DONE;
        endcase
      end
    end

    if ((state_r == S_FINISH) && out_free) begin
      out_status_r <= res_status_r;
      out_access_r <= res_access_r;
      out_count_r  <= 7'(cnt_r);
    end
  end

  // --------------------------------------------------------------------------
  // Id RAM: one write, one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) id_mem[cmp_idx_r] <= id_r;
    rdata_r <= id_mem[rd_idx_r];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_access_out  = out_access_r;
  assign out_entry_count = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PITAF_ASSERT(a_count_matches_valid, (CNT_W'($countones(valid_r)) == cnt_r), "count out of step with valid bits")
  `PITAF_ASSERT_IMPL(a_scan_within_top, (state_r == S_SCAN) && cmp_vld_r && (kind_r != KIND_ADD), (cmp_idx_r <= top_r), "lookup scan ran past high-water slot")
  `PITAF_ASSERT_NEXT(a_finish_delivers, (state_r == S_FINISH) && out_free, (state_r == S_IDLE) && out_valid_r, "finished result not loaded")
  `PITAF_ASSERT_IMPL(a_top_occupied, (cnt_r != '0), valid_r[top_r], "high-water slot empty while table in use")

endmodule

[dv/protected_id_table_access_filter_tb.sv]
// ----------------------------------------------------------------------------
// protected_id_table_access_filter_tb
// Self-checking bench for the protected id table access filter. A directed
// opening covers the special cases. Random phases follow: table fills,
// duplicates, high-water moves, and strip masks from none to all bits.
// A behavioral table predicts every reply. Both channels idle at random.
// ----------------------------------------------------------------------------
module protected_id_table_access_filter_tb import pitaf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 8;
  localparam int IDLE_PCT    = 14;    // chance per cycle that a side idles
  localparam int DRAIN_WAIT  = 80;    // idle wait before the final check; longer than the worst scan
  localparam int STUCK_LIMIT = 4000;  // cycles with no transfer on either side

  typedef struct {
    kind_t       kind;
    logic [31:0] pid;
    logic        kern;
    logic [31:0] acc;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] access;
    logic [6:0]  count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_OPEN;
  logic [31:0] in_process_id = '0;
  logic        in_kernel_handle = 1'b0;
  logic [31:0] in_access_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_access_out;
  logic [6:0]  out_entry_count;

  protected_id_table_access_filter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_process_id    (in_process_id),
    .in_kernel_handle (in_kernel_handle),
    .in_access_in     (in_access_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_access_out   (out_access_out),
    .out_entry_count  (out_entry_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench-side copy of the protected table
  // --------------------------------------------------------------------------
  logic [31:0] id_tab [SLOT_COUNT];
  int          n_used;      // occupied slots
  int          hi_slot;     // high-water slot index
  logic [31:0] strip_bits;  // mirror of strip_mask

  request_t    request_q[$];   // requests waiting for the driver
  reply_t      reply_q[$];     // predicted replies, oldest first
  logic [31:0] id_pool [16];   // small id set so lookups actually hit
  logic        in_sent = 1'b0; // current request already transferred
  logic        steady = 1'b0;  // no idling on either side while set
  int          mismatch_cnt = 0;
  int          stuck_cycles = 0;

  function automatic void empty_table();
    for (int i = 0; i < SLOT_COUNT; i++) id_tab[i] = '0;
    n_used  = 0;
    hi_slot = 0;
  endfunction

  // Applies one request to the bench table and returns the reply it must give.
  function automatic reply_t predict_reply(request_t r);
    reply_t rep;
    int     below;
    bit     hit;
    rep.status = ST_DONE;
    rep.access = '0;
    hit        = 1'b0;
    below      = 0;
    case (r.kind)
      KIND_OPEN: begin
        // kernel requester, empty table and id zero all pass unchanged
        rep.access = r.acc;
        rep.status = ST_MISS;
        if (!r.kern && n_used != 0 && r.pid != '0) begin
          for (int i = 0; i <= hi_slot; i++)
            if (id_tab[i] == r.pid) hit = 1'b1;
        end
        if (hit) begin
          rep.access = r.acc & ~strip_bits;
          rep.status = ST_DONE;
        end
      end
      KIND_ADD: begin
        if (r.pid == '0) begin
          rep.status = ST_ZERO;
        end else begin
          rep.status = ST_FULL;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (id_tab[i] == '0) begin
              id_tab[i] = r.pid;
              n_used++;
              if (i > hi_slot) hi_slot = i;
              rep.status = ST_DONE;
              break;
            end
          end
        end
      end
      KIND_REMOVE: begin
        if (r.pid == '0) begin
          rep.status = ST_ZERO;
        end else begin
          // lowest match only; a hit on the top slot drops the index to the
          // highest occupied slot seen below it
          rep.status = ST_MISS;
          for (int i = 0; i <= hi_slot; i++) begin
            if (id_tab[i] == r.pid) begin
              id_tab[i] = '0;
              if (i == hi_slot) hi_slot = below;
              if (n_used > 0) n_used--;
              rep.status = ST_DONE;
              break;
            end
            if (id_tab[i] != '0) below = i;
          end
        end
      end
      default: begin
        empty_table();
        rep.status = ST_DONE;
      end
    endcase
    rep.count = 7'(n_used);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_request(kind_t k, logic [31:0] pid, logic kern,
                                        logic [31:0] acc);
    request_t r;
    r.kind = k;
    r.pid  = pid;
    r.kern = kern;
    r.acc  = acc;
    request_q.push_back(r);
  endfunction

  // Mostly pool ids so adds, removes and lookups collide; some wild ids and zero.
  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return id_pool[$urandom_range(0, 15)];
    if (r < 93) return $urandom;
    return '0;
  endfunction

  function automatic void queue_mix(int n, int add_pct, int rem_pct, int clr_pct);
    int    r;
    kind_t k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct)                          k = KIND_ADD;
      else if (r < add_pct + rem_pct)           k = KIND_REMOVE;
      else if (r < add_pct + rem_pct + clr_pct) k = KIND_CLEAR;
      else                                      k = KIND_OPEN;
      queue_request(k, pick_id(), $urandom_range(0, 3) == 0, $urandom);
    end
  endfunction

  // Clear, then add until the table is full and a few past it.
  function automatic void queue_fill(int extra);
    queue_request(KIND_CLEAR, $urandom, 1'($urandom_range(0, 1)), $urandom);
    for (int i = 0; i < SLOT_COUNT + extra; i++)
      queue_request(KIND_ADD, id_pool[$urandom_range(0, 15)], 1'($urandom_range(0, 1)),
                    $urandom);
  endfunction

  // Block idle: nothing queued, nothing on the input, no reply outstanding.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (request_q.size() != 0 || in_valid || reply_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_strip(logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    strip_bits = value;
    @(posedge clk);
    #1;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued requests at the falling edge, holds a stalled one
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    request_t r;
    if (!in_valid || in_sent) begin
      in_sent = 1'b0;
      if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        r = request_q.pop_front();
        in_kind          <= r.kind;
        in_process_id    <= r.pid;
        in_kernel_handle <= r.kern;
        in_access_in     <= r.acc;
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, independent of anything the block does.
  always @(negedge clk)
    out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

  // --------------------------------------------------------------------------
  // Monitor: checks reply transfers, predicts on request transfers, and
  // watches for a hang. Pop before push keeps the queue order unambiguous.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t seen;
    reply_t   want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("reply transfer with none outstanding: status %0d access %h count %0d",
                 out_status, out_access_out, out_entry_count);
          mismatch_cnt++;
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatch_cnt++;
          end
          if (out_access_out !== want.access) begin
            $error("access_out: expected %h, got %h", want.access, out_access_out);
            mismatch_cnt++;
          end
          if (out_entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen.kind = kind_t'(in_kind);
        seen.pid  = in_process_id;
        seen.kern = in_kernel_handle;
        seen.acc  = in_access_in;
        reply_q.push_back(predict_reply(seen));
        in_sent = 1'b1;
      end
      // watchdog: any transfer on either side counts as progress
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("protected_id_table_access_filter verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    empty_table();
    strip_bits = STRIP_DEFAULT;
    id_pool[0] = 32'h0000_0001;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 16; i++) begin
      id_pool[i] = $urandom;
      if (id_pool[i] == '0) id_pool[i] = 32'h8000_0000;
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);
    #1;

    // Directed: reset mask, special cases in a fixed order.
    queue_request(KIND_OPEN,   32'd5,          1'b0, 32'hFFFF_FFFF); // empty table
    queue_request(KIND_ADD,    32'd0,          1'b0, $urandom);      // zero id
    queue_request(KIND_REMOVE, 32'd0,          1'b1, $urandom);      // zero id
    queue_request(KIND_REMOVE, 32'd7,          1'b0, $urandom);      // absent, count at 0
    queue_request(KIND_ADD,    32'hFFFF_FFFF,  1'b1, $urandom);
    queue_request(KIND_ADD,    32'd1,          1'b0, $urandom);
    queue_request(KIND_ADD,    32'd1,          1'b0, $urandom);      // duplicate
    queue_request(KIND_ADD,    32'h8000_0000,  1'b0, $urandom);
    queue_request(KIND_OPEN,   32'hFFFF_FFFF,  1'b0, 32'hFFFF_FFFF); // hit, strip
    queue_request(KIND_OPEN,   32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF); // kernel pass
    queue_request(KIND_OPEN,   32'd0,          1'b0, 32'hFFFF_FFFF); // id zero never hits
    queue_request(KIND_OPEN,   32'd2,          1'b0, 32'h0000_005B); // absent id
    queue_request(KIND_REMOVE, 32'd1,          1'b0, $urandom);      // lowest duplicate
    queue_request(KIND_OPEN,   32'd1,          1'b0, 32'h0000_0000); // other copy still hits
    queue_request(KIND_REMOVE, 32'h8000_0000,  1'b0, $urandom);      // top slot drops
    queue_request(KIND_REMOVE, 32'd1,          1'b0, $urandom);      // top again, down to 0
    queue_request(KIND_OPEN,   32'd1,          1'b0, 32'hFFFF_FFFF); // gone
    queue_request(KIND_ADD,    32'd5,          1'b0, $urandom);      // reuses freed slot
    queue_request(KIND_REMOVE, 32'hFFFF_FFFF,  1'b0, $urandom);      // below the top
    queue_request(KIND_OPEN,   32'd5,          1'b0, 32'h0000_005B);
    queue_request(KIND_CLEAR,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF);
    queue_request(KIND_OPEN,   32'd5,          1'b0, 32'hFFFF_FFFF); // empty after clear
    queue_request(KIND_REMOVE, 32'd5,          1'b0, $urandom);
    wait_drained();

    // All bits stripped; fill to full, overflow, then churn.
    write_strip(32'hFFFF_FFFF);
    queue_fill(3);
    queue_mix(150, 35, 30, 3);
    wait_drained();

    // Nothing stripped; long stretch with no idling on either side.
    write_strip(32'h0000_0000);
    steady = 1'b1;
    queue_mix(200, 30, 25, 3);
    wait_drained();
    steady = 1'b0;

    // Random mask with frequent clears.
    write_strip($urandom);
    queue_mix(250, 30, 30, 5);
    wait_drained();

    // Back to the default mask; full table drained by removes.
    write_strip(STRIP_DEFAULT);
    queue_fill(2);
    queue_mix(200, 20, 40, 2);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && reply_q.size() == 0)
      $display("protected_id_table_access_filter verification clean");
    else
      $display("protected_id_table_access_filter verification failed");
    $finish;
  end

endmodule

[protected_id_table_access_filter.f]
+incdir+rtl/core
rtl/core/pitaf_pkg.sv
rtl/core/protected_id_table_access_filter.sv
dv/protected_id_table_access_filter_tb.sv
